// File: design/bmprle_pkg.sv
package bmprle_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_RLE_MODE     = 2'd0;
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd2;

   // parse phase codes
   localparam logic [2:0] PH_COUNT   = 3'd0;
   localparam logic [2:0] PH_COLOR   = 3'd1;
   localparam logic [2:0] PH_ESCAPE  = 3'd2;
   localparam logic [2:0] PH_DX      = 3'd3;
   localparam logic [2:0] PH_DY      = 3'd4;
   localparam logic [2:0] PH_LITERAL = 3'd5;
   localparam logic [2:0] PH_PAD     = 3'd6;

   // escape codes following a zero count byte
   localparam logic [7:0] ESC_EOL   = 8'd0;
   localparam logic [7:0] ESC_EOB   = 8'd1;
   localparam logic [7:0] ESC_DELTA = 8'd2;

   localparam logic [7:0] NIBBLE_MASK = 8'h0f;

   // one pixel-run command
   typedef struct packed {
      logic        end_of_image;
      logic        run_clipped;
      logic [7:0]  color_second;
      logic [7:0]  color_first;
      logic [7:0]  pixel_count;
      logic [11:0] run_column;
      logic [11:0] run_row;
   } rsp_type;

endpackage

// File: design/bmp_rle_decoder.sv
// response: a run command is loaded into the response register in the cycle after its request is accepted
// throughput: one compressed byte per cycle; a request is taken whenever the
//   response register is empty or being drained in the same cycle
// reset: synchronous, active high; clears parse state, cursor, finish flag and
//   the response valid, and sets RLE8 mode with width and height of 1
module bmp_rle_decoder #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic        req_tlast,   // last_byte
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // run_row[11:0], run_column[23:12], pixel_count[31:24],
                                    // color_first[39:32], color_second[47:40]
   output logic        rsp_tuser,   // run_clipped
   output logic        rsp_tlast,   // end_of_image
   // configuration port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);

   localparam logic [12:0] WMax = 13'(MAX_WIDTH);
   localparam logic [12:0] HMax = 13'(MAX_HEIGHT);

   // configuration
   logic        rle_mode_ff;
   logic [12:0] image_width_ff;
   logic [12:0] image_height_ff;

   // parse state
   logic [2:0]  phase_ff, phase_in;
   logic [12:0] col_ff, col_in;
   logic [12:0] row_ff, row_in;
   logic [7:0]  held_count_ff, held_count_in;
   logic [7:0]  lit_pix_ff, lit_pix_in;
   logic [7:0]  lit_bytes_ff, lit_bytes_in;
   logic        pad_ff, pad_in;
   logic [7:0]  dx_ff, dx_in;
   logic        fin_ff, fin_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   bmprle_pkg::rsp_type  rsp_ff, rsp_in;

   logic        accept;
   logic [12:0] w_eff, h_eff;
   logic [7:0]  run_req;
   logic [7:0]  run_n;
   logic        run_clip;
   logic [12:0] avail;
   logic [7:0]  c_first, c_second;
   logic [7:0]  lit_n;
   logic [7:0]  bytes_dec;
   logic [12:0] col_delta;
   logic [12:0] row_step;
   logic        have_run, finish, emit;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // effective image size
   always_comb begin
      if (image_width_ff == 13'd0)     w_eff = 13'd1;
      else if (image_width_ff > WMax)  w_eff = WMax;
      else                             w_eff = image_width_ff;
      if (image_height_ff == 13'd0)    h_eff = 13'd1;
      else if (image_height_ff > HMax) h_eff = HMax;
      else                             h_eff = image_height_ff;
   end

   // run length and colours for the current byte
   always_comb begin
      if (rle_mode_ff) begin
         lit_n    = (lit_pix_ff < 8'd2) ? lit_pix_ff : 8'd2;
         c_first  = (req_tdata >> 4) & bmprle_pkg::NIBBLE_MASK;
         c_second = req_tdata & bmprle_pkg::NIBBLE_MASK;
      end else begin
         lit_n    = (lit_pix_ff < 8'd1) ? lit_pix_ff : 8'd1;
         c_first  = req_tdata;
         c_second = req_tdata;
      end
      run_req = (phase_ff == bmprle_pkg::PH_LITERAL) ? lit_n : held_count_ff;
   end

   // clip the run at the row end
   always_comb begin
      avail = (col_ff < w_eff) ? (w_eff - col_ff) : 13'd0;
      if ({5'd0, run_req} > avail) begin
         run_n    = avail[7:0];
         run_clip = 1'b1;
      end else begin
         run_n    = run_req;
         run_clip = 1'b0;
      end
   end

   assign bytes_dec = (lit_bytes_ff != 8'd0) ? (lit_bytes_ff - 8'd1) : 8'd0;
   assign col_delta = col_ff + {5'd0, dx_ff};
   assign row_step  = row_ff + {5'd0, req_tdata};

   // byte parser
   always_comb begin
      phase_in      = phase_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      held_count_in = held_count_ff;
      lit_pix_in    = lit_pix_ff;
      lit_bytes_in  = lit_bytes_ff;
      pad_in        = pad_ff;
      dx_in         = dx_ff;
      fin_in        = fin_ff;
      have_run      = 1'b0;
      finish        = 1'b0;
      emit          = 1'b0;
      rsp_in        = rsp_ff;

      if (accept && !fin_ff) begin
         if (row_ff >= h_eff) begin
            finish = 1'b1;
         end else begin
            unique case (phase_ff)
               bmprle_pkg::PH_COUNT: begin
                  if (req_tdata != 8'd0) begin
                     held_count_in = req_tdata;
                     phase_in      = bmprle_pkg::PH_COLOR;
                  end else begin
                     phase_in = bmprle_pkg::PH_ESCAPE;
                  end
               end
               bmprle_pkg::PH_COLOR: begin
                  have_run = 1'b1;
                  col_in   = col_ff + {5'd0, run_n};
                  phase_in = bmprle_pkg::PH_COUNT;
               end
               bmprle_pkg::PH_ESCAPE: begin
                  priority if (req_tdata == bmprle_pkg::ESC_EOL) begin
                     col_in   = 13'd0;
                     phase_in = bmprle_pkg::PH_COUNT;
                     if (row_ff + 13'd1 >= h_eff) begin
                        row_in = h_eff;
                        finish = 1'b1;
                     end else begin
                        row_in = row_ff + 13'd1;
                     end
                  end else if (req_tdata == bmprle_pkg::ESC_EOB) begin
                     finish   = 1'b1;
                     phase_in = bmprle_pkg::PH_COUNT;
                  end else if (req_tdata == bmprle_pkg::ESC_DELTA) begin
                     phase_in = bmprle_pkg::PH_DX;
                  end else begin
                     lit_pix_in   = req_tdata;
                     lit_bytes_in = rle_mode_ff ?
                                    8'(({1'b0, req_tdata} + 9'd1) >> 1) : req_tdata;
                     pad_in       = rle_mode_ff ?
                                    lit_bytes_in[0] : req_tdata[0];
                     phase_in     = bmprle_pkg::PH_LITERAL;
                  end
               end
               bmprle_pkg::PH_DX: begin
                  dx_in    = req_tdata;
                  phase_in = bmprle_pkg::PH_DY;
               end
               bmprle_pkg::PH_DY: begin
                  col_in   = (col_delta > w_eff) ? w_eff : col_delta;
                  phase_in = bmprle_pkg::PH_COUNT;
                  if (row_step >= h_eff) begin
                     row_in = h_eff;
                     finish = 1'b1;
                  end else begin
                     row_in = row_step;
                  end
               end
               bmprle_pkg::PH_LITERAL: begin
                  have_run     = 1'b1;
                  col_in       = col_ff + {5'd0, run_n};
                  lit_pix_in   = lit_pix_ff - lit_n;
                  lit_bytes_in = bytes_dec;
                  if (bytes_dec == 8'd0) begin
                     phase_in   = pad_ff ? bmprle_pkg::PH_PAD : bmprle_pkg::PH_COUNT;
                     pad_in     = 1'b0;
                     lit_pix_in = 8'd0;
                  end
               end
               bmprle_pkg::PH_PAD: begin
                  phase_in = bmprle_pkg::PH_COUNT;
               end
               default: begin
                  phase_in = bmprle_pkg::PH_COUNT;
               end
            endcase
            if (req_tlast) finish = 1'b1;
         end

         // fill the response
         emit = have_run || finish;
         if (finish) fin_in = 1'b1;
         if (have_run) begin
            rsp_in.run_row      = row_ff[11:0];
            rsp_in.run_column   = col_ff[11:0];
            rsp_in.pixel_count  = run_n;
            rsp_in.color_first  = c_first;
            rsp_in.color_second = c_second;
            rsp_in.run_clipped  = run_clip;
            rsp_in.end_of_image = finish;
         end else begin
            rsp_in              = '0;
            rsp_in.end_of_image = 1'b1;
         end
      end
   end

   // response valid
   always_comb begin
      if (accept && emit)  rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rle_mode_ff     <= 1'b0;
         image_width_ff  <= 13'd1;
         image_height_ff <= 13'd1;
         phase_ff        <= bmprle_pkg::PH_COUNT;
         col_ff          <= 13'd0;
         row_ff          <= 13'd0;
         held_count_ff   <= 8'd0;
         lit_pix_ff      <= 8'd0;
         lit_bytes_ff    <= 8'd0;
         pad_ff          <= 1'b0;
         dx_ff           <= 8'd0;
         fin_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               bmprle_pkg::CSR_RLE_MODE:     rle_mode_ff     <= csr_wdata[0];
               bmprle_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
               bmprle_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
               default: ;
            endcase
         end
         phase_ff      <= phase_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         held_count_ff <= held_count_in;
         lit_pix_ff    <= lit_pix_in;
         lit_bytes_ff  <= lit_bytes_in;
         pad_ff        <= pad_in;
         dx_ff         <= dx_in;
         fin_ff        <= fin_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.color_second, rsp_ff.color_first, rsp_ff.pixel_count,
                        rsp_ff.run_column, rsp_ff.run_row};
   assign rsp_tuser  = rsp_ff.run_clipped;
   assign rsp_tlast  = rsp_ff.end_of_image;

endmodule

// File: design/bmprle_checker.sv
module bmprle_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // requests are only held off by a stalled response
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request refused without a stalled response");

   // nothing follows the end of image response
   a_end_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("response after end of image");

   // reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind bmp_rle_decoder bmprle_checker u_bmprle_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
